// ----- sv/rrps_pkg.sv -----
package rrps_pkg;

   localparam int CHANNELS     = 4;
   localparam int BYTE_BITS    = 8;
   localparam int QUOT_BITS    = 8;
   localparam int DATA_BITS    = 32;
   localparam int REG_IDX_BITS = 3;
   localparam int ADDR_BITS    = REG_IDX_BITS + 2;

   localparam logic [REG_IDX_BITS-1:0] REG_DRAW_MODE   = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_RECT_WIDTH  = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_RECT_HEIGHT = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_RADIUS      = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_THICKNESS   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_TOP_COLOR   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_BOT_COLOR   = 3'd6;

   localparam logic [1:0] MODE_FILL_WRITE = 2'd0;

   typedef struct packed {
      logic                 covered;
      logic                 blend;
      logic                 use_top;
      logic [DATA_BITS-1:0] color;
   } side_type;

endpackage

// ----- sv/rrps_corner.sv -----
module rrps_corner #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]        px,
   input  logic [COORD_BITS-1:0]        py,
   input  logic [COORD_BITS-1:0]        w,
   input  logic [COORD_BITS-1:0]        h,
   input  logic [COORD_BITS-1:0]        r,
   output logic                         near,
   output logic signed [COORD_BITS+1:0] dx,
   output logic signed [COORD_BITS+1:0] dy
);
   logic [COORD_BITS-1:0] wr;
   logic [COORD_BITS-1:0] hr;
   logic [COORD_BITS-1:0] cx;
   logic [COORD_BITS-1:0] cy;
   logic                  band;

   always_comb begin
      wr   = w - r;
      hr   = h - r;
      band = ((px >= r) && (px < wr)) || ((py >= r) && (py < hr));
      near = (r == '0) || band;
      // corner circle center
      cx   = (px < r) ? r - COORD_BITS'(1) : wr;
      cy   = (py < r) ? r - COORD_BITS'(1) : hr;
      dx   = $signed({2'b00, px}) - $signed({2'b00, cx});
      dy   = $signed({2'b00, py}) - $signed({2'b00, cy});
   end

endmodule

// ----- sv/rrps_divider.sv -----
module rrps_divider #(
   parameter int DEN_BITS = 12
) (
   input  logic                                                          clock,
   input  logic                                                          reset,
   input  logic                                                          in_valid,
   output logic                                                          in_ready,
   input  logic [rrps_pkg::CHANNELS-1:0][DEN_BITS+rrps_pkg::QUOT_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0]                                           den,
   input  rrps_pkg::side_type                                            in_side,
   output logic                                                          out_valid,
   input  logic                                                          out_ready,
   output logic [rrps_pkg::CHANNELS-1:0][rrps_pkg::QUOT_BITS-1:0]        out_quot,
   output rrps_pkg::side_type                                            out_side
);
   import rrps_pkg::*;

   localparam int NUM_BITS = DEN_BITS + QUOT_BITS;

   logic                                      v_ff    [QUOT_BITS];
   logic [CHANNELS-1:0][NUM_BITS-1:0]         rem_ff  [QUOT_BITS];
   logic [CHANNELS-1:0][NUM_BITS-1:0]         rem_in  [QUOT_BITS];
   logic [CHANNELS-1:0][QUOT_BITS-1:0]        quo_ff  [QUOT_BITS];
   logic [CHANNELS-1:0][QUOT_BITS-1:0]        quo_in  [QUOT_BITS];
   side_type                                  side_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]                      en;

   always_comb begin
      en[QUOT_BITS-1] = !v_ff[QUOT_BITS-1] || out_ready;
      for (int j = QUOT_BITS - 2; j >= 0; j--) begin
         en[j] = !v_ff[j] || en[j+1];
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
      localparam int SH = QUOT_BITS - 1 - j;
      logic [CHANNELS-1:0][NUM_BITS-1:0]  rem_src;
      logic [CHANNELS-1:0][QUOT_BITS-1:0] quo_src;
      side_type                           side_src;
      logic                               v_src;
      logic [NUM_BITS-1:0]                dsh;

      if (j == 0) begin : g_first
         assign rem_src  = in_num;
         assign quo_src  = '0;
         assign side_src = in_side;
         assign v_src    = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign side_src = side_ff[j-1];
         assign v_src    = v_ff[j-1];
      end

      assign dsh = NUM_BITS'(den) << SH;

      always_comb begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (rem_src[c] >= dsh) begin
               rem_in[j][c] = rem_src[c] - dsh;
               quo_in[j][c] = quo_src[c] | (QUOT_BITS'(1) << SH);
            end else begin
               rem_in[j][c] = rem_src[c];
               quo_in[j][c] = quo_src[c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (en[j]) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]  <= rem_in[j];
            quo_ff[j]  <= quo_in[j];
            side_ff[j] <= side_src;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[QUOT_BITS-1];
   assign out_quot  = quo_ff[QUOT_BITS-1];
   assign out_side  = side_ff[QUOT_BITS-1];

endmodule

// ----- sv/rounded_rect_pixel_shader.sv -----
// Channel   Ports                                     Moves
// req       req_valid/req_ready, req_pixel_x/_y       one pixel position per word
// rsp       rsp_valid/rsp_ready, rsp_covered..alpha   one coverage and color word
// csr       psel penable pwrite paddr pwdata prdata   register write and read
//
// Four geometry stages, then one stage per quotient bit of the
// gradient divider (8 stages). One word enters per cycle while no stage is stalled.
// Every stage holds when the stage after it is full and stalled, so bubbles fill.
// Reset is synchronous; req_ready is low while reset is high.
// Registers must be written only while no word is in flight; the block does not enforce it.
module rounded_rect_pixel_shader #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [COORD_BITS-1:0]           req_pixel_x,
   input  logic [COORD_BITS-1:0]           req_pixel_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_covered,
   output logic                            rsp_blend_wanted,
   output logic [7:0]                      rsp_red,
   output logic [7:0]                      rsp_green,
   output logic [7:0]                      rsp_blue,
   output logic [7:0]                      rsp_alpha,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rrps_pkg::ADDR_BITS-1:0]  paddr,
   input  logic [rrps_pkg::DATA_BITS-1:0]  pwdata,
   output logic [rrps_pkg::DATA_BITS-1:0]  prdata,
   output logic                            pready
);
   import rrps_pkg::*;

   localparam int C        = COORD_BITS;
   localparam int NUM_BITS = C + QUOT_BITS;
   localparam int DX_BITS  = C + 2;
   localparam int SQ_BITS  = 2 * C + 5;

   // registers
   logic [1:0]           mode_ff;
   logic [C-1:0]         width_ff;
   logic [C-1:0]         height_ff;
   logic [C-1:0]         radius_ff;
   logic [C-1:0]         thick_ff;
   logic [DATA_BITS-1:0] top_ff;
   logic [DATA_BITS-1:0] bot_ff;
   logic                 csr_wr;
   logic [REG_IDX_BITS-1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[ADDR_BITS-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_FILL_WRITE;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= '0;
         thick_ff  <= C'(1);
         top_ff    <= '0;
         bot_ff    <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DRAW_MODE:   mode_ff   <= pwdata[1:0];
            REG_RECT_WIDTH:  width_ff  <= pwdata[C-1:0];
            REG_RECT_HEIGHT: height_ff <= pwdata[C-1:0];
            REG_RADIUS:      radius_ff <= pwdata[C-1:0];
            REG_THICKNESS:   thick_ff  <= pwdata[C-1:0];
            REG_TOP_COLOR:   top_ff    <= pwdata;
            REG_BOT_COLOR:   bot_ff    <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DRAW_MODE:   prdata = DATA_BITS'(mode_ff);
         REG_RECT_WIDTH:  prdata = DATA_BITS'(width_ff);
         REG_RECT_HEIGHT: prdata = DATA_BITS'(height_ff);
         REG_RADIUS:      prdata = DATA_BITS'(radius_ff);
         REG_THICKNESS:   prdata = DATA_BITS'(thick_ff);
         REG_TOP_COLOR:   prdata = top_ff;
         REG_BOT_COLOR:   prdata = bot_ff;
         default:         prdata = '0;
      endcase
   end

   // shape constants, refreshed every cycle from the registers
   logic [C-1:0]   mn, cap, rlim_in, ir, mni, capi, rin_in, wi_in, hi_in, den_in;
   logic [C:0]     t2;
   logic [C-1:0]   rlim_ff, rin_ff, wi_ff, hi_ff, den_ff;
   logic [2*C-1:0] r2o_ff, r2i_ff;

   always_comb begin
      t2      = {thick_ff, 1'b0};
      mn      = (width_ff < height_ff) ? width_ff : height_ff;
      cap     = mn >> 1;
      rlim_in = (radius_ff > cap) ? cap : radius_ff;
      wi_in   = width_ff - t2[C-1:0];
      hi_in   = height_ff - t2[C-1:0];
      ir      = (rlim_in > thick_ff) ? rlim_in - thick_ff : '0;
      mni     = (wi_in < hi_in) ? wi_in : hi_in;
      capi    = mni >> 1;
      rin_in  = (ir > capi) ? capi : ir;
      den_in  = (height_ff > C'(1)) ? height_ff - C'(1) : C'(1);
   end

   always_ff @(posedge clock) begin
      rlim_ff <= rlim_in;
      rin_ff  <= rin_in;
      wi_ff   <= wi_in;
      hi_ff   <= hi_in;
      den_ff  <= den_in;
      r2o_ff  <= rlim_ff * rlim_ff;
      r2i_ff  <= rin_ff * rin_ff;
   end

   // stage handshake
   logic [3:0] sv_ff;
   logic [3:0] en;
   logic       div_in_ready;

   always_comb begin
      en[3] = !sv_ff[3] || div_in_ready;
      for (int i = 2; i >= 0; i--) begin
         en[i] = !sv_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0] && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else begin
         if (en[0]) begin
            sv_ff[0] <= req_valid;
         end
         for (int i = 1; i < 4; i++) begin
            if (en[i]) begin
               sv_ff[i] <= sv_ff[i-1];
            end
         end
      end
   end

   // stage 1: window and inset tests
   logic [C-1:0] x1_ff, y1_ff;
   logic [C:0]   xt, yt;
   logic         base_in, pre_in, stroke;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x1_ff <= req_pixel_x;
         y1_ff <= req_pixel_y;
      end
   end

   always_comb begin
      stroke  = mode_ff[1];
      xt      = {1'b0, x1_ff} + {1'b0, thick_ff};
      yt      = {1'b0, y1_ff} + {1'b0, thick_ff};
      base_in = (width_ff != '0) && (height_ff != '0) && (x1_ff < width_ff)
                && (y1_ff < height_ff) && !(stroke && (thick_ff == '0));
      pre_in  = ({1'b0, width_ff} > t2) && ({1'b0, height_ff} > t2)
                && (x1_ff >= thick_ff) && (y1_ff >= thick_ff)
                && (xt < {1'b0, width_ff}) && (yt < {1'b0, height_ff});
   end

   // stage 2: bands, corner offsets, gradient products
   logic [C-1:0] x2_ff, y2_ff, xi2_ff, yi2_ff;
   logic         base2_ff, pre2_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         xi2_ff   <= x1_ff - thick_ff;
         yi2_ff   <= y1_ff - thick_ff;
         base2_ff <= base_in;
         pre2_ff  <= pre_in;
      end
   end

   logic                      near_o, near_i;
   logic signed [DX_BITS-1:0] dxo, dyo, dxi, dyi;

   rrps_corner #(.COORD_BITS(C)) u_outer (
      .px(x2_ff), .py(y2_ff), .w(width_ff), .h(height_ff), .r(rlim_ff),
      .near(near_o), .dx(dxo), .dy(dyo)
   );

   rrps_corner #(.COORD_BITS(C)) u_inner (
      .px(xi2_ff), .py(yi2_ff), .w(wi_ff), .h(hi_ff), .r(rin_ff),
      .near(near_i), .dx(dxi), .dy(dyi)
   );

   logic [C-1:0]                      yrest;
   logic [CHANNELS-1:0][NUM_BITS-1:0] pa_in, pb_in;

   always_comb begin
      yrest = den_ff - y2_ff;
      for (int k = 0; k < CHANNELS; k++) begin
         pa_in[k] = NUM_BITS'(top_ff[DATA_BITS-1-BYTE_BITS*k -: BYTE_BITS])
                    * NUM_BITS'(yrest);
         pb_in[k] = NUM_BITS'(bot_ff[DATA_BITS-1-BYTE_BITS*k -: BYTE_BITS])
                    * NUM_BITS'(y2_ff);
      end
   end

   // stage 3: squared distances, gradient numerators
   logic                              near_o3_ff, near_i3_ff, base3_ff, pre3_ff;
   logic signed [DX_BITS-1:0]         dxo3_ff, dyo3_ff, dxi3_ff, dyi3_ff;
   logic [CHANNELS-1:0][NUM_BITS-1:0] pa3_ff, pb3_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         near_o3_ff <= near_o;
         near_i3_ff <= near_i;
         base3_ff   <= base2_ff;
         pre3_ff    <= pre2_ff;
         dxo3_ff    <= dxo;
         dyo3_ff    <= dyo;
         dxi3_ff    <= dxi;
         dyi3_ff    <= dyi;
         pa3_ff     <= pa_in;
         pb3_ff     <= pb_in;
      end
   end

   logic signed [2*DX_BITS-1:0]       pxo, pyo, pxi, pyi;
   logic [SQ_BITS-1:0]                sqo_in, sqi_in;
   logic [CHANNELS-1:0][NUM_BITS-1:0] num_in;

   always_comb begin
      pxo    = dxo3_ff * dxo3_ff;
      pyo    = dyo3_ff * dyo3_ff;
      pxi    = dxi3_ff * dxi3_ff;
      pyi    = dyi3_ff * dyi3_ff;
      sqo_in = SQ_BITS'($unsigned(pxo)) + SQ_BITS'($unsigned(pyo));
      sqi_in = SQ_BITS'($unsigned(pxi)) + SQ_BITS'($unsigned(pyi));
      for (int k = 0; k < CHANNELS; k++) begin
         num_in[k] = pa3_ff[k] + pb3_ff[k] + NUM_BITS'(den_ff >> 1);
      end
   end

   // stage 4: coverage decision, then on to the divider
   logic                              near_o4_ff, near_i4_ff, base4_ff, pre4_ff;
   logic [SQ_BITS-1:0]                sqo4_ff, sqi4_ff;
   logic [CHANNELS-1:0][NUM_BITS-1:0] num4_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         near_o4_ff <= near_o3_ff;
         near_i4_ff <= near_i3_ff;
         base4_ff   <= base3_ff;
         pre4_ff    <= pre3_ff;
         sqo4_ff    <= sqo_in;
         sqi4_ff    <= sqi_in;
         num4_ff    <= num_in;
      end
   end

   logic     in_outer, in_hole;
   side_type side_in;

   always_comb begin
      in_outer        = near_o4_ff || (sqo4_ff <= SQ_BITS'(r2o_ff));
      in_hole         = pre4_ff && (near_i4_ff || (sqi4_ff <= SQ_BITS'(r2i_ff)));
      side_in.covered = base4_ff && in_outer && !(stroke && in_hole);
      side_in.blend   = side_in.covered && (mode_ff != MODE_FILL_WRITE);
      side_in.use_top = stroke;
      side_in.color   = top_ff;
   end

   logic                               div_out_valid;
   logic [CHANNELS-1:0][QUOT_BITS-1:0] quot;
   side_type                           side_out;

   rrps_divider #(.DEN_BITS(C)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sv_ff[3]),
      .in_ready  (div_in_ready),
      .in_num    (num4_ff),
      .den       (den_ff),
      .in_side   (side_in),
      .out_valid (div_out_valid),
      .out_ready (rsp_ready),
      .out_quot  (quot),
      .out_side  (side_out)
   );

   logic [DATA_BITS-1:0] color;

   always_comb begin
      if (!side_out.covered) begin
         color = '0;
      end else if (side_out.use_top) begin
         color = side_out.color;
      end else begin
         color = {quot[0], quot[1], quot[2], quot[3]};
      end
   end

   assign rsp_valid        = div_out_valid;
   assign rsp_covered      = side_out.covered;
   assign rsp_blend_wanted = side_out.blend;
   assign rsp_red          = color[31:24];
   assign rsp_green        = color[23:16];
   assign rsp_blue         = color[15:8];
   assign rsp_alpha        = color[7:0];

endmodule

// ----- sv/rrps_checker.sv -----
module rrps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_covered,
   input logic       rsp_blend_wanted,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_alpha,
   input logic       pready
);

   // nothing in flight right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // undrawn pixels carry no color and no blend
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_covered |-> !rsp_blend_wanted && rsp_red == 8'd0
         && rsp_green == 8'd0 && rsp_blue == 8'd0 && rsp_alpha == 8'd0)
      else $error("undrawn pixel with nonzero fields");

   // blend only on drawn pixels
   a_blend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blend_wanted |-> rsp_covered)
      else $error("blend on undrawn pixel");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready || req_ready)
      else $error("pready low");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_covered)
         && $stable(rsp_red) && $stable(rsp_alpha))
      else $error("stalled result word changed");

endmodule

bind rounded_rect_pixel_shader rrps_checker u_rrps_checker (.*);

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rrps_pkg::*;

   localparam int LATENCY = 12;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
   } pixel_type;

   typedef struct packed {
      logic       covered;
      logic       blend;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } shade_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [11:0] req_pixel_x = 0, req_pixel_y = 0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_covered, rsp_blend_wanted;
   logic [7:0] rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [ADDR_BITS-1:0] paddr = 0;
   logic [DATA_BITS-1:0] pwdata = 0;
   logic [DATA_BITS-1:0] prdata;
   logic pready;

   rounded_rect_pixel_shader dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shader settings mirrored in the testbench
   logic [1:0]  mode_q;
   logic [11:0] width_q, height_q, radius_q, thick_q;
   logic [31:0] top_q, bottom_q;

   pixel_type pending_pixels[$];
   shade_type expected_shades[$];
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  feeding = 0;
   int  failures = 0;
   int  quiet_cycles = 0;

   function automatic int clamp_radius(int w, int h, int r);
      int cap;
      cap = (w < h ? w : h) / 2;
      return r > cap ? cap : r;
   endfunction

   function automatic bit inside_shape(int x, int y, int w, int h, int r);
      longint cx, cy, dx, dy;
      if (w == 0 || h == 0) return 0;
      r = clamp_radius(w, h, r);
      if (r == 0) return 1;
      if (x >= r && x < w - r) return 1;
      if (y >= r && y < h - r) return 1;
      cx = (x < r) ? r - 1 : w - r;
      cy = (y < r) ? r - 1 : h - r;
      dx = x - cx;
      dy = y - cy;
      return dx * dx + dy * dy <= longint'(r) * r;
   endfunction

   function automatic shade_type shade_pixel(pixel_type p);
      shade_type s;
      int x, y, w, h, t, r, den;
      bit stroke, hole;
      logic [31:0] color;
      logic [31:0] v;
      x = p.x; y = p.y; w = width_q; h = height_q; t = thick_q;
      stroke = mode_q[1];
      color = 0;
      s = '0;
      if (w != 0 && h != 0 && x < w && y < h && !(stroke && t == 0) &&
          inside_shape(x, y, w, h, radius_q)) begin
         if (stroke) begin
            r = clamp_radius(w, h, radius_q);
            hole = 0;
            if (w > 2 * t && h > 2 * t && x >= t && y >= t && x < w - t && y < h - t)
               hole = inside_shape(x - t, y - t, w - 2 * t, h - 2 * t, r > t ? r - t : 0);
            if (!hole) begin
               s.covered = 1;
               color = top_q;
            end
         end else begin
            den = h > 1 ? h - 1 : 1;
            s.covered = 1;
            for (int k = 0; k < 4; k++) begin
               v = top_q[24-8*k +: 8] * (den - y) + bottom_q[24-8*k +: 8] * y + den / 2;
               color[24-8*k +: 8] = 8'(v / den);
            end
         end
      end
      s.blend = s.covered && mode_q != MODE_FILL_WRITE;
      {s.red, s.green, s.blue, s.alpha} = color;
      return s;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (feeding && pending_pixels.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1;
               req_pixel_x <= pending_pixels[0].x;
               req_pixel_y <= pending_pixels[0].y;
               pending_pixels.pop_front();
            end else begin
               req_valid <= 0;
            end
         end
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // monitor
   always @(posedge clock) begin
      shade_type got, want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (req_valid && req_ready) begin
            expected_shades.push_back(shade_pixel({req_pixel_x, req_pixel_y}));
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_covered, rsp_blend_wanted, rsp_red, rsp_green, rsp_blue, rsp_alpha};
            if (expected_shades.size() == 0) begin
               $error("result word with nothing expected");
               failures++;
            end else begin
               want = expected_shades.pop_front();
               if (got.covered !== want.covered) begin
                  $error("covered exp %0d got %0d", want.covered, got.covered); failures++;
               end
               if (got.blend !== want.blend) begin
                  $error("blend_wanted exp %0d got %0d", want.blend, got.blend); failures++;
               end
               if (got.red !== want.red) begin
                  $error("red exp %0d got %0d", want.red, got.red); failures++;
               end
               if (got.green !== want.green) begin
                  $error("green exp %0d got %0d", want.green, got.green); failures++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue exp %0d got %0d", want.blue, got.blue); failures++;
               end
               if (got.alpha !== want.alpha) begin
                  $error("alpha exp %0d got %0d", want.alpha, got.alpha); failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_DRAW_MODE:   mode_q = value[1:0];
         REG_RECT_WIDTH:  width_q = value[11:0];
         REG_RECT_HEIGHT: height_q = value[11:0];
         REG_RADIUS:      radius_q = value[11:0];
         REG_THICKNESS:   thick_q = value[11:0];
         REG_TOP_COLOR:   top_q = value;
         default:         bottom_q = value;
      endcase
   endtask

   task automatic set_shape(int mode, int w, int h, int r, int t);
      write_reg(REG_DRAW_MODE, mode);
      write_reg(REG_RECT_WIDTH, w);
      write_reg(REG_RECT_HEIGHT, h);
      write_reg(REG_RADIUS, r);
      write_reg(REG_THICKNESS, t);
      write_reg(REG_TOP_COLOR, $urandom);
      write_reg(REG_BOT_COLOR, $urandom);
   endtask

   // let the pipeline empty before touching registers
   task automatic drain();
      feeding = 1;
      wait (pending_pixels.size() == 0 && !req_valid);
      wait (expected_shades.size() == 0);
      feeding = 0;
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic queue_pixel(int x, int y);
      pixel_type p;
      p.x = x; p.y = y;
      pending_pixels.push_back(p);
   endtask

   task automatic random_phase(int count);
      int w, h;
      w = width_q; h = height_q;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0 || w == 0 || h == 0)
            queue_pixel($urandom_range(4095), $urandom_range(4095));
         else
            queue_pixel($urandom_range(w - 1), $urandom_range(h - 1));
      end
   endtask

   initial begin
      int w, h;
      mode_q = 0; width_q = 0; height_q = 0; radius_q = 0; thick_q = 1;
      top_q = 0; bottom_q = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // reset state: empty rectangle draws nothing
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      drain();

      set_shape(0, 40, 30, 8, 3);
      queue_pixel(0, 0); queue_pixel(39, 29); queue_pixel(20, 0);
      queue_pixel(0, 15); queue_pixel(2, 2); queue_pixel(40, 5); queue_pixel(5, 30);
      drain();
      set_shape(2, 40, 30, 4095, 3);
      queue_pixel(0, 15); queue_pixel(3, 15); queue_pixel(20, 15); queue_pixel(36, 2);
      drain();
      set_shape(3, 10, 1, 2, 0);
      queue_pixel(3, 0); queue_pixel(0, 0);
      drain();
      set_shape(1, 4095, 1, 0, 4095);
      queue_pixel(4094, 0); queue_pixel(0, 0);
      drain();
      set_shape(2, 6, 6, 1, 3);
      queue_pixel(3, 3); queue_pixel(0, 0);
      drain();
      set_shape(1, 4095, 4095, 4095, 1);
      write_reg(REG_TOP_COLOR, 32'hffffffff);
      write_reg(REG_BOT_COLOR, 32'h0);
      queue_pixel(2047, 2047); queue_pixel(4094, 4094); queue_pixel(0, 2047);
      drain();

      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         if (ph == 15) begin
            w = 4095; h = 4095;
         end else begin
            w = $urandom_range(1, 64); h = $urandom_range(1, 64);
         end
         set_shape($urandom_range(3), w, h, $urandom_range(0, 40), $urandom_range(0, 12));
         random_phase(100);
         drain();
      end

      send_idle_pct = 0; recv_stall_pct = 0;
      if (failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
